// ===== src/sv39_page_table_map_and_lookup_top_macros.svh =====
// Assertion macros for the page table walker RTL.
`ifndef SV39_PAGE_TABLE_MAP_AND_LOOKUP_TOP_MACROS_SVH
`define SV39_PAGE_TABLE_MAP_AND_LOOKUP_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SV39PTW_ASSERT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define SV39PTW_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SV39PTW_ASSERT(name, clk, rst_n, ante, cons, msg)
`define SV39PTW_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/sv39ptw_pkg.sv =====
// Package with widths, codes, control word types and the microprogram.
`default_nettype none
package sv39ptw_pkg;

    localparam int VA_W             = 39;
    localparam int PA_W             = 56;
    localparam int PERM_W           = 8;
    localparam int ENTRY_W          = 54;
    localparam int STATUS_W         = 2;
    localparam int PPN_W            = 44;
    localparam int IDX_W            = 9;
    localparam int ENTRIES_PER_PAGE = 512;
    localparam int SHIFT_L1         = 30;
    localparam int SHIFT_L2         = 21;
    localparam int SHIFT_L3         = 12;
    localparam int PPN_SHIFT        = 10;
    localparam int POOL_PAGES_DEF   = 64;

    localparam logic [PPN_W-1:0] POOL_BASE_RESET = 44'd524288;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL  = 2'd2;

    typedef logic [3:0] t_step;

    localparam t_step S_CLR     = 4'd0;
    localparam t_step S_IDLE    = 4'd1;
    localparam t_step S_RD1     = 4'd2;
    localparam t_step S_CK1     = 4'd3;
    localparam t_step S_RD2     = 4'd4;
    localparam t_step S_CK2     = 4'd5;
    localparam t_step S_RD3     = 4'd6;
    localparam t_step S_LKOUT   = 4'd7;
    localparam t_step S_FULLCK  = 4'd8;
    localparam t_step S_WRP1    = 4'd9;
    localparam t_step S_WRP2    = 4'd10;
    localparam t_step S_WRLF    = 4'd11;
    localparam t_step S_NOTMAP  = 4'd12;
    localparam t_step S_FULLOUT = 4'd13;

    typedef enum logic [1:0] {
        A_CLR,
        A_L1,
        A_L2,
        A_L3
    } t_asel;

    typedef enum logic [1:0] {
        W_ZERO,
        W_PTR,
        W_LEAF
    } t_wsel;

    typedef enum logic [1:0] {
        R_RDATA,
        R_LEAF,
        R_NOTMAP,
        R_FULL
    } t_rsel;

    typedef enum logic [3:0] {
        C_NEVER,
        C_CLR_BUSY,
        C_NO_IN,
        C_FAIL,
        C_V1_INV,
        C_LOOKUP,
        C_V2,
        C_FULL,
        C_HAVE1,
        C_OUT_BUSY
    } t_cond;

    // Datapath controls of one microinstruction.
    typedef struct packed {
        logic  take;
        t_asel asel;
        logic  rd_en;
        logic  wr_en;
        t_wsel wsel;
        logic  ld_p2;
        logic  ld_p3;
        logic  alloc;
        logic  res_en;
        t_rsel rsel;
    } t_ctl;

    // Status flags that the datapath returns for branching.
    typedef struct packed {
        logic no_in;
        logic clr_busy;
        logic fail;
        logic rd_valid;
        logic lookup;
        logic full;
        logic have1;
        logic out_busy;
    } t_flags;

    // Three prioritised conditional jumps, then a default successor.
    typedef struct packed {
        t_ctl  ctl;
        t_cond ca;
        t_step ta;
        t_cond cb;
        t_step tb;
        t_cond cc;
        t_step tc;
        t_step tn;
    } t_uword;

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = '0;
        case (s)
            S_CLR: begin
                w.ctl.asel  = A_CLR;
                w.ctl.wr_en = 1'b1;
                w.ctl.wsel  = W_ZERO;
                w.ca = C_CLR_BUSY;
                w.ta = S_CLR;
                w.tn = S_IDLE;
            end
            S_IDLE: begin
                w.ctl.take = 1'b1;
                w.ca = C_NO_IN;
                w.ta = S_IDLE;
                w.tn = S_RD1;
            end
            S_RD1: begin
                w.ctl.rd_en = 1'b1;
                w.ctl.asel  = A_L1;
                w.tn = S_CK1;
            end
            S_CK1: begin
                w.ctl.ld_p2 = 1'b1;
                w.ca = C_FAIL;
                w.ta = S_NOTMAP;
                w.cb = C_V1_INV;
                w.tb = S_FULLCK;
                w.tn = S_RD2;
            end
            S_RD2: begin
                w.ctl.rd_en = 1'b1;
                w.ctl.asel  = A_L2;
                w.tn = S_CK2;
            end
            S_CK2: begin
                w.ctl.ld_p3 = 1'b1;
                w.ca = C_FAIL;
                w.ta = S_NOTMAP;
                w.cb = C_LOOKUP;
                w.tb = S_RD3;
                w.cc = C_V2;
                w.tc = S_WRLF;
                w.tn = S_FULLCK;
            end
            S_RD3: begin
                w.ctl.rd_en = 1'b1;
                w.ctl.asel  = A_L3;
                w.tn = S_LKOUT;
            end
            S_LKOUT: begin
                w.ctl.res_en = 1'b1;
                w.ctl.rsel   = R_RDATA;
                w.ca = C_OUT_BUSY;
                w.ta = S_LKOUT;
                w.tn = S_IDLE;
            end
            S_FULLCK: begin
                w.ca = C_FULL;
                w.ta = S_FULLOUT;
                w.cb = C_HAVE1;
                w.tb = S_WRP2;
                w.tn = S_WRP1;
            end
            S_WRP1: begin
                w.ctl.wr_en = 1'b1;
                w.ctl.asel  = A_L1;
                w.ctl.wsel  = W_PTR;
                w.ctl.alloc = 1'b1;
                w.ctl.ld_p2 = 1'b1;
                w.tn = S_WRP2;
            end
            S_WRP2: begin
                w.ctl.wr_en = 1'b1;
                w.ctl.asel  = A_L2;
                w.ctl.wsel  = W_PTR;
                w.ctl.alloc = 1'b1;
                w.ctl.ld_p3 = 1'b1;
                w.tn = S_WRLF;
            end
            S_WRLF: begin
                // Rewriting the same leaf while the output stalls is harmless.
                w.ctl.wr_en  = 1'b1;
                w.ctl.asel   = A_L3;
                w.ctl.wsel   = W_LEAF;
                w.ctl.res_en = 1'b1;
                w.ctl.rsel   = R_LEAF;
                w.ca = C_OUT_BUSY;
                w.ta = S_WRLF;
                w.tn = S_IDLE;
            end
            S_NOTMAP: begin
                w.ctl.res_en = 1'b1;
                w.ctl.rsel   = R_NOTMAP;
                w.ca = C_OUT_BUSY;
                w.ta = S_NOTMAP;
                w.tn = S_IDLE;
            end
            S_FULLOUT: begin
                w.ctl.res_en = 1'b1;
                w.ctl.rsel   = R_FULL;
                w.ca = C_OUT_BUSY;
                w.ta = S_FULLOUT;
                w.tn = S_IDLE;
            end
            default: begin
                w.tn = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== src/sv39ptw_ifs.sv =====
// Handshake interfaces for the request and result channels.
`default_nettype none
interface sv39ptw_item_if
    import sv39ptw_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   phys_addr;
    logic [PERM_W-1:0] perm_bits;

    modport source (output valid, output mode, output virt_addr, output phys_addr,
                    output perm_bits, input ready);
    modport sink   (input valid, input mode, input virt_addr, input phys_addr,
                    input perm_bits, output ready);
endinterface

interface sv39ptw_result_if
    import sv39ptw_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ENTRY_W-1:0]  entry;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output entry, output status, input ready);
    modport sink   (input valid, input entry, input status, output ready);
endinterface
`default_nettype wire

// ===== src/sv39_page_table_map_and_lookup_top.sv =====
// Top level of the Sv39 page table map and lookup engine.
//
//  Channel    Direction  Handshake        Payload
//  i_item     in         valid/ready      mode, virt_addr, phys_addr, perm_bits
//  o_result   out        valid/ready      entry, status
//  cfg        in         i_cfg_we         i_cfg_wdata (pool_base_ppn)
//
// A lookup reads the three levels in turn; a map reads the upper levels until one is missing,
// then writes a pointer for each missing upper level and finally the leaf.
// Reads and writes share the table's single address port, so every read or write is one
// access, and each level's read must return before the next address is known.
// After reset the table store is cleared one entry per cycle, all POOL_PAGES * 512 entries
// (32768 at the default), with i_item.ready low; configuration writes are taken throughout.
// A result waits in an output register, and the engine holds in its result step while
// that register is full and not being taken.
`default_nettype none
module sv39_page_table_map_and_lookup_top
    import sv39ptw_pkg::*;
#(
    parameter int POOL_PAGES = POOL_PAGES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    sv39ptw_item_if.sink          i_item,
    sv39ptw_result_if.source      o_result,
    input  wire logic             i_cfg_we,
    input  wire logic [PPN_W-1:0] i_cfg_wdata
);
    localparam int DEPTH = POOL_PAGES * ENTRIES_PER_PAGE;
    localparam int AW    = $clog2(DEPTH);

    t_ctl               ctl;
    t_flags             flags;
    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    sv39ptw_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctl   (ctl)
    );

    sv39ptw_dpath #(
        .POOL_PAGES (POOL_PAGES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctl       (ctl),
        .o_flags     (flags),
        .o_ram_we    (ram_we),
        .o_ram_re    (ram_re),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata)
    );

    sv39ptw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );
endmodule
`default_nettype wire

// ===== src/sv39ptw_ram.sv =====
// Generic single write port RAM with one registered read port.
`default_nettype none
module sv39ptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== src/sv39ptw_useq.sv =====
// Microprogram sequencer: step counter, control store and branch logic.
`default_nettype none
module sv39ptw_useq
    import sv39ptw_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_flags i_flags,
    output t_ctl        o_ctl
);
    t_step  r_step;
    t_step  n_step;
    t_uword w_word;

    function automatic logic cond_hit(input t_cond c, input t_flags f);
        logic hit;
        case (c)
            C_NEVER:    hit = 1'b0;
            C_CLR_BUSY: hit = f.clr_busy;
            C_NO_IN:    hit = f.no_in;
            C_FAIL:     hit = f.fail;
            C_V1_INV:   hit = !f.rd_valid;
            C_LOOKUP:   hit = f.lookup;
            C_V2:       hit = f.rd_valid;
            C_FULL:     hit = f.full;
            C_HAVE1:    hit = f.have1;
            C_OUT_BUSY: hit = f.out_busy;
            default:    hit = 1'b0;
        endcase
        return hit;
    endfunction

    assign w_word = ucode(r_step);
    assign o_ctl  = w_word.ctl;

    always_comb begin
        if (cond_hit(w_word.ca, i_flags)) begin
            n_step = w_word.ta;
        end else if (cond_hit(w_word.cb, i_flags)) begin
            n_step = w_word.tb;
        end else if (cond_hit(w_word.cc, i_flags)) begin
            n_step = w_word.tc;
        end else begin
            n_step = w_word.tn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_CLR;
        end else begin
            r_step <= n_step;
        end
    end
endmodule
`default_nettype wire

// ===== src/sv39ptw_dpath.sv =====
// Datapath: item and walk registers, page allocator, address and data muxes, result slot.
`default_nettype none
`include "sv39_page_table_map_and_lookup_top_macros.svh"
module sv39ptw_dpath
    import sv39ptw_pkg::*;
#(
    parameter int POOL_PAGES = POOL_PAGES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    sv39ptw_item_if.sink              i_item,
    sv39ptw_result_if.source          o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [PPN_W-1:0]     i_cfg_wdata,
    input  wire t_ctl                 i_ctl,
    output t_flags                    o_flags,
    output logic                      o_ram_we,
    output logic                      o_ram_re,
    output logic [$clog2(POOL_PAGES * ENTRIES_PER_PAGE)-1:0] o_ram_addr,
    output logic [ENTRY_W-1:0]        o_ram_wdata,
    input  wire logic [ENTRY_W-1:0]   i_ram_rdata
);
    localparam int DEPTH = POOL_PAGES * ENTRIES_PER_PAGE;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = AW - IDX_W;
    localparam int NW    = $clog2(POOL_PAGES + 1);

    logic [PPN_W-1:0]    r_base;
    logic                r_mode;
    logic [IDX_W-1:0]    r_i1;
    logic [IDX_W-1:0]    r_i2;
    logic [IDX_W-1:0]    r_i3;
    logic [ENTRY_W-1:0]  r_leaf;
    logic [PW-1:0]       r_p2;
    logic [PW-1:0]       r_p3;
    logic                r_v1;
    logic [NW-1:0]       r_next_free;
    logic [AW-1:0]       r_clr;
    logic                r_out_valid;
    logic [ENTRY_W-1:0]  r_entry;
    logic [STATUS_W-1:0] r_status;

    logic [PPN_W-1:0]    rel;
    logic                rel_ok;
    logic [PPN_W-1:0]    ptr_ppn;
    logic [ENTRY_W-1:0]  ptr_entry;
    logic [NW:0]         need_sum;
    logic                accept;
    logic                out_busy;
    logic                res_ld;
    logic [ENTRY_W-1:0]  res_entry;
    logic [STATUS_W-1:0] res_status;

    // Offset of a pointer's page number from the pool base, wrapping at 44 bits.
    assign rel     = i_ram_rdata[ENTRY_W-1:PPN_SHIFT] - r_base;
    assign rel_ok  = rel < PPN_W'(POOL_PAGES);
    assign ptr_ppn = r_base + PPN_W'(r_next_free);
    assign ptr_entry = {ptr_ppn, (PPN_SHIFT - 1)'(0), 1'b1};

    // A fresh first level needs two pages, otherwise one.
    assign need_sum = {1'b0, r_next_free} + (r_v1 ? (NW + 1)'(1) : (NW + 1)'(2));

    assign accept   = i_item.valid && i_ctl.take;
    assign out_busy = r_out_valid && !o_result.ready;
    assign res_ld   = i_ctl.res_en && !out_busy;

    assign i_item.ready = i_ctl.take;

    assign o_flags.no_in    = !i_item.valid;
    assign o_flags.clr_busy = r_clr != AW'(DEPTH - 1);
    assign o_flags.fail     = i_ram_rdata[0] ? !rel_ok : r_mode;
    assign o_flags.rd_valid = i_ram_rdata[0];
    assign o_flags.lookup   = r_mode;
    assign o_flags.full     = need_sum > (NW + 1)'(POOL_PAGES);
    assign o_flags.have1    = r_v1;
    assign o_flags.out_busy = out_busy;

    always_comb begin
        case (i_ctl.asel)
            A_CLR:   o_ram_addr = r_clr;
            A_L1:    o_ram_addr = {PW'(0), r_i1};
            A_L2:    o_ram_addr = {r_p2, r_i2};
            A_L3:    o_ram_addr = {r_p3, r_i3};
            default: o_ram_addr = r_clr;
        endcase
    end

    always_comb begin
        case (i_ctl.wsel)
            W_ZERO:  o_ram_wdata = '0;
            W_PTR:   o_ram_wdata = ptr_entry;
            W_LEAF:  o_ram_wdata = r_leaf;
            default: o_ram_wdata = '0;
        endcase
    end

    assign o_ram_we = i_ctl.wr_en;
    assign o_ram_re = i_ctl.rd_en;

    always_comb begin
        case (i_ctl.rsel)
            R_RDATA: begin
                res_entry  = i_ram_rdata;
                res_status = ST_OK;
            end
            R_LEAF: begin
                res_entry  = r_leaf;
                res_status = ST_OK;
            end
            R_NOTMAP: begin
                res_entry  = '0;
                res_status = ST_NOT_MAPPED;
            end
            R_FULL: begin
                res_entry  = '0;
                res_status = ST_POOL_FULL;
            end
            default: begin
                res_entry  = '0;
                res_status = ST_NOT_MAPPED;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= POOL_BASE_RESET;
            r_next_free <= NW'(1);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (i_ctl.alloc) begin
                r_next_free <= r_next_free + NW'(1);
            end
            if (i_ctl.wr_en && (i_ctl.asel == A_CLR)) begin
                r_clr <= r_clr + AW'(1);
            end
            if (res_ld) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_item.mode;
            r_i1   <= i_item.virt_addr[SHIFT_L1 +: IDX_W];
            r_i2   <= i_item.virt_addr[SHIFT_L2 +: IDX_W];
            r_i3   <= i_item.virt_addr[SHIFT_L3 +: IDX_W];
            r_leaf <= {i_item.phys_addr[PA_W-1:SHIFT_L3], (PPN_SHIFT - PERM_W)'(0),
                       i_item.perm_bits[PERM_W-1:1], 1'b1};
        end
        if (i_ctl.ld_p2) begin
            r_p2 <= i_ctl.alloc ? r_next_free[PW-1:0] : rel[PW-1:0];
            if (!i_ctl.alloc) begin
                r_v1 <= i_ram_rdata[0];
            end
        end
        if (i_ctl.ld_p3) begin
            r_p3 <= i_ctl.alloc ? r_next_free[PW-1:0] : rel[PW-1:0];
        end
        if (res_ld) begin
            r_entry  <= res_entry;
            r_status <= res_status;
        end
    end

    assign o_result.valid  = r_out_valid;
    assign o_result.entry  = r_entry;
    assign o_result.status = r_status;

    `SV39PTW_ASSERT(a_free_bound, i_clk, i_rst_n, 1'b1, (r_next_free >= NW'(1)) && (r_next_free <= NW'(POOL_PAGES)), "allocation counter out of range")
    `SV39PTW_ASSERT(a_alloc_room, i_clk, i_rst_n, i_ctl.alloc, r_next_free < NW'(POOL_PAGES), "page allocated from an exhausted pool")
    `SV39PTW_ASSERT(a_no_write_idle, i_clk, i_rst_n, o_ram_we, !i_item.ready, "table written while taking a request")
    `SV39PTW_ASSERT_NEXT(a_full_keeps, i_clk, i_rst_n, res_ld && (i_ctl.rsel == R_FULL), $stable(r_next_free), "pool full result changed the allocator")
endmodule
`default_nettype wire
